/* src/vgsd_pkg.sv */
// Shared types, mode codes and square-root digit step for the video gamma core.
`default_nettype none
package vgsd_pkg;

   localparam int CH_W   = 8;
   localparam int RND_W  = 15;
   localparam int DITH_W = 6;
   localparam int OP_W   = CH_W + DITH_W;
   localparam int ROOT_W = OP_W / 2;
   localparam int DIG_W  = 3;

   localparam logic [1:0] MODE_PASS   = 2'd0;
   localparam logic [1:0] MODE_DITHER = 2'd1;
   localparam logic [1:0] MODE_GAMMA  = 2'd2;
   localparam logic [1:0] MODE_BOTH   = 2'd3;

   localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

   typedef struct packed {
      logic [CH_W-1:0]  red;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  blue;
      logic [RND_W-1:0] random_bits;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0] red_out;
      logic [CH_W-1:0] green_out;
      logic [CH_W-1:0] blue_out;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]   rem;
      logic [ROOT_W-1:0] root;
   } root_lane_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic [CH_W-1:0]     pix_r;
      logic [CH_W-1:0]     pix_g;
      logic [CH_W-1:0]     pix_b;
      root_lane_type [2:0] lane;
   } pipe_data_type;

   // One digit of the restoring square root: remainder holds v - root^2.
   function automatic root_lane_type root_digit(root_lane_type lane_in,
                                                logic [DIG_W-1:0] k);
      root_lane_type   lane_out;
      logic [OP_W:0]   trial;
      logic [OP_W:0]   rem_ext;
      lane_out = lane_in;
      trial    = ((OP_W+1)'(lane_in.root) << (k + 1'b1)) |
                 ((OP_W+1)'(1) << {k, 1'b0});
      rem_ext  = {1'b0, lane_in.rem};
      if (rem_ext >= trial) begin
         lane_out.rem  = OP_W'(rem_ext - trial);
         lane_out.root = lane_in.root | (ROOT_W'(1) << k);
      end
      return lane_out;
   endfunction

endpackage
`default_nettype wire

/* src/vgsd_root_stage.sv */
// One pipeline stage of the three-lane square root, resolving one root digit.
`default_nettype none
module vgsd_root_stage (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  [vgsd_pkg::DIG_W-1:0]   digit,
   input  wire                          valid_in,
   input  vgsd_pkg::pipe_data_type      data_in,
   output logic                         valid_out,
   output vgsd_pkg::pipe_data_type      data_out
);
   import vgsd_pkg::*;

   logic          valid_ff;
   pipe_data_type data_ff;
   pipe_data_type data_in_d;

   always_comb begin
      data_in_d = data_in;
      for (int i = 0; i < 3; i++) begin
         data_in_d.lane[i] = root_digit(data_in.lane[i], digit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in_d;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule
`default_nettype wire

/* src/video_gamma_sqrt_dither_core.sv */
// Top level of the video gamma / dither core: register file, entry stage, root pipe, output.
// Pipeline: an accepted item passes the entry register, seven square-root digit stages and the
// output register before the result strobe rises and the result is taken.
// Throughput: one item per cycle in every mode; busy stays low and the receiver cannot stall.
// Reset: synchronous, active high; clears both mode bits and all stage valid bits.
`default_nettype none
module video_gamma_sqrt_dither_core (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  vgsd_pkg::req_type  req_data,
   output logic               rsp_strobe,
   output vgsd_pkg::rsp_type  rsp_data,
   input  wire                psel,
   input  wire                penable,
   input  wire                pwrite,
   input  wire  [2:0]         paddr,
   input  wire  [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import vgsd_pkg::*;

   localparam int NSTAGE = ROOT_W + 1;

   logic gamma_on_ff;
   logic dither_on_ff;
   logic cfg_wr;

   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign cfg_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_on_ff  <= 1'b0;
         dither_on_ff <= 1'b0;
      end else if (cfg_wr) begin
         if (paddr[2]) begin
            dither_on_ff <= pwdata[0];
         end else begin
            gamma_on_ff <= pwdata[0];
         end
      end
   end

   assign prdata = {31'b0, (paddr[2] ? dither_on_ff : gamma_on_ff)};

   // entry stage: dither add and root operands
   pipe_data_type      entry_in;
   logic [1:0]         mode;
   logic [DITH_W-1:0]  d_r, d_g, d_b;
   logic [RND_W-1:0]   rnd;

   assign mode = {gamma_on_ff, dither_on_ff};
   assign rnd  = req_data.random_bits;

   always_comb begin
      entry_in       = '0;
      entry_in.mode  = mode;
      entry_in.pix_r = req_data.red;
      entry_in.pix_g = req_data.green;
      entry_in.pix_b = req_data.blue;
      d_r = '0;
      d_g = '0;
      d_b = '0;
      if (mode == MODE_DITHER) begin
         if (req_data.red != CH_MAX) begin
            entry_in.pix_r = req_data.red + CH_W'(rnd[0]);
         end
         if (req_data.green != CH_MAX) begin
            entry_in.pix_g = req_data.green + CH_W'(rnd[1]);
         end
         if (req_data.blue != CH_MAX) begin
            entry_in.pix_b = req_data.blue + CH_W'(rnd[2]);
         end
      end
      if (mode == MODE_BOTH) begin
         d_r = rnd[5:0];
         d_g = rnd[11:6];
         d_b = {rnd[14:12], rnd[2:0]};
      end
      entry_in.lane[0].rem  = {req_data.red, d_r};
      entry_in.lane[1].rem  = {req_data.green, d_g};
      entry_in.lane[2].rem  = {req_data.blue, d_b};
   end

   logic          stage_valid [0:NSTAGE-1];
   pipe_data_type stage_data  [0:NSTAGE-1];
   logic          entry_valid_ff;
   pipe_data_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign stage_valid[0] = entry_valid_ff;
   assign stage_data[0]  = entry_ff;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      vgsd_root_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .digit     (DIG_W'(ROOT_W - 1 - k)),
         .valid_in  (stage_valid[k]),
         .data_in   (stage_data[k]),
         .valid_out (stage_valid[k+1]),
         .data_out  (stage_data[k+1])
      );
   end

   // output select
   pipe_data_type last;
   logic          rsp_strobe_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;

   assign last = stage_data[NSTAGE-1];

   always_comb begin
      if (last.mode[1]) begin
         rsp_in.red_out   = {last.lane[0].root, 1'b0};
         rsp_in.green_out = {last.lane[1].root, 1'b0};
         rsp_in.blue_out  = {last.lane[2].root, 1'b0};
      end else begin
         rsp_in.red_out   = last.pix_r;
         rsp_in.green_out = last.pix_g;
         rsp_in.blue_out  = last.pix_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= stage_valid[NSTAGE-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##9 rsp_strobe)
      else $error("accepted item produced no result");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 9))
      else $error("result without accepted item");

   a_gamma_even: assert property (@(posedge clock) disable iff (reset)
      (stage_valid[NSTAGE-1] && last.mode[1]) |=>
         (!rsp_data.red_out[0] && !rsp_data.green_out[0] && !rsp_data.blue_out[0]))
      else $error("gamma output not even");
`endif

endmodule
`default_nettype wire

/* sim/video_gamma_sqrt_dither_core_tb.sv */
// Self-checking testbench for the video gamma / dither core: predictor, scoreboard, drivers.
`timescale 1ns / 100ps
module video_gamma_sqrt_dither_core_tb;
   import vgsd_pkg::*;

   localparam logic [2:0] ADDR_GAMMA_ON  = 3'd0;
   localparam logic [2:0] ADDR_DITHER_ON = 3'd4;
   localparam int CORNER_ITEMS  = 6;
   localparam int RAND_PHASES   = 8;
   localparam int PHASE_ITEMS   = 50;
   localparam int DRAIN_CYCLES  = 12;

   class pixel_scoreboard;
      bit      gamma_en;
      bit      dither_en;
      rsp_type pixel_q[$];
      int      errors;
      int      checked;
      int      mode_hits[4];

      function logic [CH_W-1:0] gamma_root(logic [CH_W-1:0] c, logic [DITH_W-1:0] d);
         int v;
         int r;
         v = {c, d};
         r = 0;
         for (int i = 0; i < 128; i++)
            if (i * i <= v) r = i;
         return CH_W'(r << 1);
      endfunction

      function logic [CH_W-1:0] dither_inc(logic [CH_W-1:0] c, logic b);
         return (c == CH_MAX) ? c : c + CH_W'(b);
      endfunction

      function rsp_type predict_pixel(req_type px);
         rsp_type           o;
         logic [DITH_W-1:0] dr, dg, db;
         logic [14:0]       rnd;
         rnd = px.random_bits;
         o.red_out   = px.red;
         o.green_out = px.green;
         o.blue_out  = px.blue;
         case ({gamma_en, dither_en})
            MODE_DITHER: begin
               o.red_out   = dither_inc(px.red,   rnd[0]);
               o.green_out = dither_inc(px.green, rnd[1]);
               o.blue_out  = dither_inc(px.blue,  rnd[2]);
            end
            MODE_GAMMA: begin
               o.red_out   = gamma_root(px.red,   '0);
               o.green_out = gamma_root(px.green, '0);
               o.blue_out  = gamma_root(px.blue,  '0);
            end
            MODE_BOTH: begin
               dr = rnd[5:0];
               dg = rnd[11:6];
               db = {rnd[14:12], rnd[2:0]};
               o.red_out   = gamma_root(px.red,   dr);
               o.green_out = gamma_root(px.green, dg);
               o.blue_out  = gamma_root(px.blue,  db);
            end
            default: ;
         endcase
         return o;
      endfunction

      function void note_pixel(req_type px);
         mode_hits[{gamma_en, dither_en}]++;
         pixel_q.push_back(predict_pixel(px));
      endfunction

      function void check_pixel(rsp_type got);
         rsp_type want;
         if (pixel_q.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
         end
         want = pixel_q.pop_front();
         checked++;
         if (got.red_out !== want.red_out) begin
            $error("red_out expected %0d actual %0d", want.red_out, got.red_out);
            errors++;
         end
         if (got.green_out !== want.green_out) begin
            $error("green_out expected %0d actual %0d", want.green_out, got.green_out);
            errors++;
         end
         if (got.blue_out !== want.blue_out) begin
            $error("blue_out expected %0d actual %0d", want.blue_out, got.blue_out);
            errors++;
         end
      endfunction
   endclass

   logic        clock   = 1'b0;
   logic        reset   = 1'b1;
   logic        start   = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [2:0]  paddr   = '0;
   logic [31:0] pwdata  = '0;
   logic [31:0] prdata;
   logic        pready;

   pixel_scoreboard sb = new();
   int              sent;
   int              settings;

   video_gamma_sqrt_dither_core DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_pixel(req_data);
         if (rsp_strobe) sb.check_pixel(rsp_data);
      end
   end

   task automatic write_reg(input logic [2:0] addr, input bit value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {31'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (!pready) @(negedge clock);
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_GAMMA_ON) sb.gamma_en = value;
      else sb.dither_en = value;
   endtask

   task automatic set_mode(input logic [1:0] mode);
      start <= 1'b0;
      while (sb.pixel_q.size() != 0) @(posedge clock);
      write_reg(ADDR_GAMMA_ON, mode[1]);
      write_reg(ADDR_DITHER_ON, mode[0]);
      settings++;
   endtask

   task automatic send_pixel(input req_type px);
      start    <= 1'b1;
      req_data <= px;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      sent++;
   endtask

   task automatic idle_gap();
      start    <= 1'b0;
      req_data <= req_type'({$urandom, $urandom});
      repeat ($urandom_range(1, 7)) @(posedge clock);
   endtask

   function automatic logic [CH_W-1:0] pick_level();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd254;
         2: return CH_MAX;
         default: return CH_W'($urandom);
      endcase
   endfunction

   initial begin
      req_type     px;
      logic [1:0]  mode;
      bit          quiet;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // corner pixels under every mode
      for (int m = 0; m < 4; m++) begin
         set_mode(2'(m));
         for (int k = 0; k < CORNER_ITEMS; k++) begin
            case (k)
               0: px = '{8'd0,   8'd0,   8'd0,   15'h0000};
               1: px = '{8'd255, 8'd255, 8'd255, 15'h7FFF};
               2: px = '{8'd254, 8'd254, 8'd254, 15'h7FFF};
               3: px = '{8'd255, 8'd0,   8'd128, 15'h5555};
               4: px = '{8'd1,   8'd2,   8'd3,   15'h7007};
               default: px = '{8'd127, 8'd64, 8'd200, 15'h0038};
            endcase
            send_pixel(px);
            if ($urandom_range(0, 3) == 0) idle_gap();
         end
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         mode  = (p < 4) ? 2'(3 - p) : 2'($urandom_range(0, 3));
         quiet = (p == RAND_PHASES - 1);
         if (!quiet) idle_gap();
         start <= 1'b0;
         set_mode(mode);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            px.red         = pick_level();
            px.green       = pick_level();
            px.blue        = pick_level();
            px.random_bits = 15'($urandom);
            send_pixel(px);
            if (!quiet && $urandom_range(0, 3) == 0) idle_gap();
         end
      end

      start <= 1'b0;
      while (sb.pixel_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d pixels over %0d mode settings, %0d results checked",
               sent, settings, sb.checked);
      $display("summary: pixels per mode pass/dither/gamma/both = %0d/%0d/%0d/%0d",
               sb.mode_hits[MODE_PASS], sb.mode_hits[MODE_DITHER],
               sb.mode_hits[MODE_GAMMA], sb.mode_hits[MODE_BOTH]);
      if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("tb: failure");
      $finish;
   end

endmodule
